>>> hw/rtl/erdo_pkg.sv
// Shared constants for the drop-oldest event ring.
package erdo_pkg;

	// default ring size
	localparam int DEPTH_DEF = 32;

	// item field widths
	localparam int LEN_W   = 6;
	localparam int SEC_W   = 32;
	localparam int USEC_W  = 20;
	localparam int TYPE_W  = 16;
	localparam int CODE_W  = 16;
	localparam int VALUE_W = 32;
	localparam int STAMP_W = SEC_W + USEC_W;
	localparam int EVENT_W = TYPE_W + CODE_W + VALUE_W;

	// action codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// "messages were dropped" marker shown in place of the new head's event
	localparam logic [TYPE_W-1:0]  MARK_TYPE  = 16'h0000;
	localparam logic [CODE_W-1:0]  MARK_CODE  = 16'd3;
	localparam logic [VALUE_W-1:0] MARK_VALUE = 32'd1;

endpackage

>>> hw/rtl/event_ring_drop_oldest.sv
// Drop-oldest event ring: top level with stamp and event memories.
// An accepted item loads the memory read and the read stage; the output register takes the
// result from the read stage when the output is not stalled.
// Throughput: one item per cycle while results are taken; each item needs one pointer update
// and at most one memory access per store.
// A stalled output holds one result and one more item may wait in the read stage behind it.
// Reset clears pointers, count, drop mark and valid flags; the memories are not cleared and
// need no clearing pass, since only written entries are ever read.
module event_ring_drop_oldest #(
	parameter int DEPTH = erdo_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic                                batch_first,
	input  logic [erdo_pkg::LEN_W-1:0]          batch_len,
	input  logic [erdo_pkg::SEC_W-1:0]          stamp_sec,
	input  logic [erdo_pkg::USEC_W-1:0]         stamp_usec,
	input  logic [erdo_pkg::TYPE_W-1:0]         event_type,
	input  logic [erdo_pkg::CODE_W-1:0]         event_code,
	input  logic signed [erdo_pkg::VALUE_W-1:0] event_value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                popped_valid,
	output logic [erdo_pkg::SEC_W-1:0]          out_sec,
	output logic [erdo_pkg::USEC_W-1:0]         out_usec,
	output logic [erdo_pkg::TYPE_W-1:0]         out_type,
	output logic [erdo_pkg::CODE_W-1:0]         out_code,
	output logic signed [erdo_pkg::VALUE_W-1:0] out_value,
	output logic [erdo_pkg::LEN_W-1:0]          dropped_now,
	output logic [erdo_pkg::LEN_W-1:0]          occupancy
);
	import erdo_pkg::*;

	// AW: ring pointer, CNT_W: fill count (0..DEPTH), CW: count math, at least batch length width
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int SW    = CW + 1;

	// Ring storage, one write port and one read port each.
	logic [STAMP_W-1:0] stamp_mem [DEPTH];
	logic [EVENT_W-1:0] event_mem [DEPTH];

	// Ring control state.
	logic [AW-1:0]    head_q, wr_q;
	logic [CNT_W-1:0] fill_q;
	// The drop marker only ever sits on the current head, so a single flag stands in for
	// rewriting that entry: set when a drop leaves entries behind, cleared by a pop or a drop that leaves none.
	logic             mark_q;

	// Read stage.
	logic               s1_valid_q;
	logic               pop_ok_s1;
	logic               mark_s1;
	logic [LEN_W-1:0]   drop_s1;
	logic [LEN_W-1:0]   occ_s1;
	logic [STAMP_W-1:0] rd_stamp_s1;
	logic [EVENT_W-1:0] rd_event_s1;

	logic acc;
	logic s1_adv;
	logic is_pop;
	logic pop_ok;

	logic [CW-1:0]    fill_c, blen_c, need_c, room_c, drop_c, kept_c, occ_c;
	logic [SW-1:0]    hsum_c;
	logic [AW-1:0]    head_inc_c, wr_inc_c, head_nx_c;
	logic [CNT_W-1:0] fill_nx_c;
	logic             mark_nx_c;

	assign s1_adv   = !out_valid || !out_stall;
	assign in_stall = s1_valid_q && !s1_adv;
	assign acc      = in_valid && !in_stall;
	assign is_pop   = (action == ACT_POP);
	assign pop_ok   = (fill_q != '0);

	always_comb begin
		fill_c = CW'(fill_q);
		blen_c = CW'(batch_len);

		// batch length: 0 counts as 1, above DEPTH counts as DEPTH
		need_c = CW'(1);
		if (batch_first) begin
			if (blen_c == '0) begin
				need_c = CW'(1);
			end else if (blen_c > CW'(DEPTH)) begin
				need_c = CW'(DEPTH);
			end else begin
				need_c = blen_c;
			end
		end

		// need never exceeds DEPTH, so the overflow never exceeds the fill
		room_c = CW'(DEPTH) - fill_c;
		drop_c = (need_c > room_c) ? (need_c - room_c) : '0;
		kept_c = fill_c - drop_c;

		// head advance by the drop count: sum stays below twice DEPTH
		hsum_c = SW'(head_q) + SW'(drop_c);
		if (hsum_c >= SW'(DEPTH)) begin
			hsum_c = hsum_c - SW'(DEPTH);
		end

		head_inc_c = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
		wr_inc_c   = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);

		if (is_pop) begin
			if (pop_ok) begin
				head_nx_c = head_inc_c;
				fill_nx_c = fill_q - CNT_W'(1);
				mark_nx_c = 1'b0;
			end else begin
				head_nx_c = head_q;
				fill_nx_c = fill_q;
				mark_nx_c = mark_q;
			end
		end else begin
			head_nx_c = AW'(hsum_c);
			fill_nx_c = CNT_W'(kept_c) + CNT_W'(1);
			mark_nx_c = (drop_c != '0) ? (kept_c != '0) : mark_q;
		end
		occ_c = CW'(fill_nx_c);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			wr_q       <= '0;
			fill_q     <= '0;
			mark_q     <= 1'b0;
			s1_valid_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (acc) begin
				head_q <= head_nx_c;
				fill_q <= fill_nx_c;
				mark_q <= mark_nx_c;
				if (!is_pop) begin
					wr_q <= wr_inc_c;
				end
			end
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid <= s1_valid_q;
			end
		end
	end

	// memories: push writes at the write pointer, pop reads the head
	always_ff @(posedge clk) begin
		if (acc && !is_pop) begin
			stamp_mem[wr_q] <= {stamp_sec, stamp_usec};
			event_mem[wr_q] <= {event_type, event_code, event_value};
		end
		if (acc && is_pop) begin
			rd_stamp_s1 <= stamp_mem[head_q];
			rd_event_s1 <= event_mem[head_q];
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pop_ok_s1 <= is_pop && pop_ok;
			mark_s1   <= mark_q;
			drop_s1   <= is_pop ? '0 : LEN_W'(drop_c);
			occ_s1    <= LEN_W'(occ_c);
		end
	end

	// output register; pushes and empty pops show zero message fields
	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			popped_valid <= pop_ok_s1;
			dropped_now  <= drop_s1;
			occupancy    <= occ_s1;
			if (pop_ok_s1) begin
				out_sec  <= rd_stamp_s1[STAMP_W-1:USEC_W];
				out_usec <= rd_stamp_s1[USEC_W-1:0];
				if (mark_s1) begin
					out_type  <= MARK_TYPE;
					out_code  <= MARK_CODE;
					out_value <= MARK_VALUE;
				end else begin
					out_type  <= rd_event_s1[EVENT_W-1:CODE_W+VALUE_W];
					out_code  <= rd_event_s1[CODE_W+VALUE_W-1:VALUE_W];
					out_value <= rd_event_s1[VALUE_W-1:0];
				end
			end else begin
				out_sec   <= '0;
				out_usec  <= '0;
				out_type  <= '0;
				out_code  <= '0;
				out_value <= '0;
			end
		end
	end

	// fill never exceeds the ring size
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above ring size");

	// a drop mark implies a non-empty ring
	a_mark_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q |-> (fill_q != '0))
		else $error("drop mark on empty ring");

	// pointers coincide exactly when the ring is empty or full
	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == wr_q) |-> (fill_q == '0 || fill_q == CNT_W'(DEPTH)))
		else $error("pointers equal with partial fill");

	// an accepted pop of a non-empty ring shrinks the fill by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_pop && pop_ok) |=> (fill_q == $past(fill_q) - CNT_W'(1)))
		else $error("pop did not shrink fill");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the drop-oldest event ring with its own ring predictor.
module tb_top;
	import erdo_pkg::*;

	localparam int RING        = DEPTH_DEF;
	localparam int HOLD_CYCLES = 150;
	localparam int LIMIT       = 500000;
	localparam int DRAIN_WAIT  = 20;
	localparam int MAX_PRINTS  = 30;

	// one input item as the sender offers it
	typedef struct packed {
		logic                     act;
		logic                     first;
		logic [LEN_W-1:0]         len;
		logic [SEC_W-1:0]         sec;
		logic [USEC_W-1:0]        usec;
		logic [TYPE_W-1:0]        typ;
		logic [CODE_W-1:0]        code;
		logic signed [VALUE_W-1:0] value;
	} ring_item_t;

	// one result item as the block returns it
	typedef struct packed {
		logic                     popped;
		logic [SEC_W-1:0]         sec;
		logic [USEC_W-1:0]        usec;
		logic [TYPE_W-1:0]        typ;
		logic [CODE_W-1:0]        code;
		logic signed [VALUE_W-1:0] value;
		logic [LEN_W-1:0]         dropped;
		logic [LEN_W-1:0]         occ;
	} ring_result_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic                      action      = ACT_PUSH;
	logic                      batch_first = 1'b0;
	logic [LEN_W-1:0]          batch_len   = '0;
	logic [SEC_W-1:0]          stamp_sec   = '0;
	logic [USEC_W-1:0]         stamp_usec  = '0;
	logic [TYPE_W-1:0]         event_type  = '0;
	logic [CODE_W-1:0]         event_code  = '0;
	logic signed [VALUE_W-1:0] event_value = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic                      popped_valid;
	logic [SEC_W-1:0]          out_sec;
	logic [USEC_W-1:0]         out_usec;
	logic [TYPE_W-1:0]         out_type;
	logic [CODE_W-1:0]         out_code;
	logic signed [VALUE_W-1:0] out_value;
	logic [LEN_W-1:0]          dropped_now;
	logic [LEN_W-1:0]          occupancy;

	event_ring_drop_oldest #(.DEPTH(RING)) u_dut (.*);

	always #2 clk = ~clk;

	// predictor copy of the ring
	logic [SEC_W-1:0]          ring_sec   [RING];
	logic [USEC_W-1:0]         ring_usec  [RING];
	logic [TYPE_W-1:0]         ring_type  [RING];
	logic [CODE_W-1:0]         ring_code  [RING];
	logic signed [VALUE_W-1:0] ring_value [RING];
	int ring_head = 0;
	int ring_wr   = 0;
	int ring_fill = 0;

	ring_result_t pending_results[$];

	// sender and receiver controls
	int stall_pct     = 0;
	int hold_requests = 0;
	int max_gap       = 0;
	int burst_left    = 0;

	// bookkeeping
	int n_sent       = 0;
	int n_checked    = 0;
	int n_fail       = 0;
	int n_push       = 0;
	int n_pop_hit    = 0;
	int n_pop_empty  = 0;
	int n_drop_items = 0;
	int n_marks      = 0;
	int n_wipes      = 0;
	int n_in_held    = 0;
	int n_cycles     = 0;

	// Work out the result of one accepted item and advance the ring copy.
	function automatic ring_result_t ring_predict(input ring_item_t it);
		ring_result_t r;
		int need;
		int room;
		int drop;
		r    = '0;
		drop = 0;
		if (it.act == ACT_POP) begin
			if (ring_fill > 0) begin
				r.popped  = 1'b1;
				r.sec     = ring_sec[ring_head];
				r.usec    = ring_usec[ring_head];
				r.typ     = ring_type[ring_head];
				r.code    = ring_code[ring_head];
				r.value   = ring_value[ring_head];
				ring_head = (ring_head + 1) % RING;
				ring_fill--;
				n_pop_hit++;
			end else begin
				n_pop_empty++;
			end
		end else begin
			// batch length clamps to 1..RING; followers only need one slot
			need = 1;
			if (it.first) begin
				need = it.len;
				if (need == 0)
					need = 1;
				if (need > RING)
					need = RING;
			end
			room = RING - ring_fill;
			if (need > room) begin
				drop = need - room;
				if (drop > ring_fill)
					drop = ring_fill;
				ring_head = (ring_head + drop) % RING;
				ring_fill -= drop;
				n_drop_items++;
				// surviving head keeps its stamp, event becomes the drop mark
				if (ring_fill > 0) begin
					ring_type[ring_head]  = MARK_TYPE;
					ring_code[ring_head]  = MARK_CODE;
					ring_value[ring_head] = MARK_VALUE;
					n_marks++;
				end else begin
					n_wipes++;
				end
			end
			ring_sec[ring_wr]   = it.sec;
			ring_usec[ring_wr]  = it.usec;
			ring_type[ring_wr]  = it.typ;
			ring_code[ring_wr]  = it.code;
			ring_value[ring_wr] = it.value;
			ring_wr = (ring_wr + 1) % RING;
			ring_fill++;
			n_push++;
		end
		r.dropped = LEN_W'(drop);
		r.occ     = LEN_W'(ring_fill);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		n_fail++;
		if (n_fail <= MAX_PRINTS)
			$display("MISMATCH result %0d %s: got %0h expected %0h", n_checked, what, got, want);
	endtask

	task automatic compare_result(input ring_result_t want);
		if (popped_valid !== want.popped)
			report_mismatch("popped_valid", 64'(popped_valid), 64'(want.popped));
		if (out_sec !== want.sec)
			report_mismatch("out_sec", 64'(out_sec), 64'(want.sec));
		if (out_usec !== want.usec)
			report_mismatch("out_usec", 64'(out_usec), 64'(want.usec));
		if (out_type !== want.typ)
			report_mismatch("out_type", 64'(out_type), 64'(want.typ));
		if (out_code !== want.code)
			report_mismatch("out_code", 64'(out_code), 64'(want.code));
		if (out_value !== want.value)
			report_mismatch("out_value", 64'(unsigned'(out_value)), 64'(unsigned'(want.value)));
		if (dropped_now !== want.dropped)
			report_mismatch("dropped_now", 64'(dropped_now), 64'(want.dropped));
		if (occupancy !== want.occ)
			report_mismatch("occupancy", 64'(occupancy), 64'(want.occ));
	endtask

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin : check_results
		ring_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(occupancy), 64'd0);
			end else begin
				want = pending_results.pop_front();
				compare_result(want);
			end
			n_checked++;
		end
	end

	// Receiver stall pattern: runs of stall/free, plus long hold-offs on request.
	always @(posedge clk) begin : recv_pattern
		static int hold_served = 0;
		static int hold_left   = 0;
		static int run_left    = 0;
		logic run_stalled;
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (run_left == 0) begin
				run_left    = $urandom_range(1, 8);
				run_stalled = ($urandom_range(99) < stall_pct);
			end
			run_left--;
			out_stall <= run_stalled;
		end
	end

	// Watchdog and input hold-off count.
	always @(posedge clk) begin
		n_cycles++;
		if (in_valid && in_stall)
			n_in_held++;
		if (n_cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", n_cycles,
				pending_results.size());
			$display("tb_top failed");
			$finish;
		end
	end

	// Offer one item and hold it until accepted; valid stays high afterwards.
	task automatic send_item(input ring_item_t it);
		in_valid    <= 1'b1;
		action      <= it.act;
		batch_first <= it.first;
		batch_len   <= it.len;
		stamp_sec   <= it.sec;
		stamp_usec  <= it.usec;
		event_type  <= it.typ;
		event_code  <= it.code;
		event_value <= it.value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(ring_predict(it));
		n_sent++;
	endtask

	// Sender works in bursts with random gaps between them.
	task automatic offer_item(input ring_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_item(it);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic ring_item_t make_push(input logic first, input int len,
			input logic [SEC_W-1:0] sec, input logic [USEC_W-1:0] usec,
			input logic [TYPE_W-1:0] typ, input logic [CODE_W-1:0] code,
			input logic [VALUE_W-1:0] value);
		ring_item_t it;
		it.act   = ACT_PUSH;
		it.first = first;
		it.len   = LEN_W'(len);
		it.sec   = sec;
		it.usec  = usec;
		it.typ   = typ;
		it.code  = code;
		it.value = value;
		return it;
	endfunction

	// Push with random payload; usec covers values past one million too.
	function automatic ring_item_t random_push(input logic first, input int len);
		ring_item_t it;
		it = make_push(first, len, $urandom(), USEC_W'($urandom()), TYPE_W'($urandom()),
			CODE_W'($urandom()), $urandom());
		case ($urandom_range(15))
			0: it.usec = USEC_W'($urandom_range(0, 999999));
			1: begin
				it.sec   = '0;
				it.value = {1'b1, {(VALUE_W-1){1'b0}}};
			end
			2: begin
				it.sec   = '1;
				it.value = {1'b0, {(VALUE_W-1){1'b1}}};
			end
			3: begin
				it.typ  = MARK_TYPE;
				it.code = MARK_CODE;
			end
			default: ;
		endcase
		return it;
	endfunction

	// Pop carries random payload bits, which the block must ignore.
	function automatic ring_item_t pop_item();
		ring_item_t it;
		it     = random_push(1'($urandom_range(1)), $urandom_range(0, 63));
		it.act = ACT_POP;
		return it;
	endfunction

	// Well-formed batches with random content, pop runs in between.
	task automatic run_batches(input int n_items, input int pop_pct, input int big_pct);
		int stop;
		int len;
		stop = n_sent + n_items;
		while (n_sent < stop) begin
			if ($urandom_range(99) < pop_pct) begin
				repeat ($urandom_range(1, 6)) offer_item(pop_item());
			end else begin
				len = ($urandom_range(99) < big_pct) ? $urandom_range(9, 32) :
					$urandom_range(1, 8);
				offer_item(random_push(1'b1, len));
				for (int i = 1; i < len; i++) begin
					if ($urandom_range(99) < 5)
						offer_item(pop_item());
					// follower length field is junk the block must not read
					offer_item(random_push(1'b0, $urandom_range(0, 63)));
				end
			end
		end
	endtask

	// Edge cases: empty pop, clamped lengths, marked head, full wipe, field extremes.
	task automatic test_directed();
		max_gap = 0;
		stall_pct <= 0;
		offer_item(pop_item());
		offer_item(make_push(1'b1, 0, '0, '0, '0, '0, '0));
		offer_item(make_push(1'b0, 63, '1, '1, '1, '1, 32'h7fff_ffff));
		offer_item(make_push(1'b0, 0, 32'h1234_5678, 20'd999999, 16'h8000, 16'h0001,
			32'h8000_0000));
		repeat (4) offer_item(pop_item());
		offer_item(make_push(1'b1, 3, 32'd10, 20'd1, 16'd1, 16'd2, 32'd3));
		offer_item(make_push(1'b0, 0, 32'd11, 20'd2, 16'd4, 16'd5, 32'hffff_fffa));
		offer_item(make_push(1'b0, 0, 32'd12, 20'd3, 16'd7, 16'd8, 32'd9));
		// len 31 with three held: two oldest dropped, third marked
		offer_item(make_push(1'b1, 31, 32'd20, 20'd4, 16'haaaa, 16'h5555, 32'd42));
		offer_item(pop_item());
		// len 63 clamps to full ring: the one held message goes, no mark left
		offer_item(make_push(1'b1, 63, 32'd30, 20'd1000000, 16'hffff, 16'h0000, 32'd7));
		repeat (2) offer_item(pop_item());
		offer_item(make_push(1'b1, 32, 32'hffff_fffe, 20'h80000, 16'h00ff, 16'hff00,
			32'h0000_ffff));
		offer_item(pop_item());
		wait_results_done();
	endtask

	task automatic test_batches_no_idle();
		max_gap = 0;
		stall_pct <= 0;
		run_batches(500, 35, 15);
		wait_results_done();
	endtask

	task automatic test_batches_idle();
		max_gap = 6;
		stall_pct <= 50;
		run_batches(500, 35, 15);
		wait_results_done();
	endtask

	// Receiver holds off long while the sender keeps offering, so the block backs up.
	task automatic test_backpressure();
		max_gap = 0;
		stall_pct <= 0;
		hold_requests <= hold_requests + 1;
		run_batches(100, 30, 20);
		wait_results_done();
	endtask

	// Push-heavy traffic keeps the ring full and dropping; then pops drain it.
	task automatic test_fill_drain();
		max_gap = 3;
		stall_pct <= 20;
		run_batches(250, 8, 40);
		run_batches(250, 80, 10);
		wait_results_done();
	endtask

	// Unstructured items: stray followers, odd lengths, pops anywhere.
	task automatic test_noise();
		int stop;
		max_gap = 4;
		stall_pct <= 30;
		stop = n_sent + 300;
		while (n_sent < stop) begin
			if ($urandom_range(1))
				offer_item(pop_item());
			else
				offer_item(random_push(1'($urandom_range(1)), $urandom_range(0, 63)));
		end
		wait_results_done();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_batches_no_idle();
		test_batches_idle();
		test_backpressure();
		test_fill_drain();
		test_noise();
		stall_pct <= 0;
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("run: %0d items, %0d pushes, %0d pops with a message, %0d pops on empty",
			n_sent, n_push, n_pop_hit, n_pop_empty);
		$display("drops on %0d pushes (%0d marked heads, %0d full wipes), input held %0d cycles",
			n_drop_items, n_marks, n_wipes, n_in_held);
		if (n_fail == 0 && pending_results.size() == 0) begin
			$display("tb_top passed");
		end else begin
			if (pending_results.size() != 0)
				$display("%0d expected results never arrived", pending_results.size());
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/erdo_pkg.sv
hw/rtl/event_ring_drop_oldest.sv
verif/tb_top.sv
